// ===== hdl/tcspq_pkg.sv =====
// Types and constants shared by the three-class priority queue files.
package tcspq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_BITS  = 2;
  localparam int TAG_W       = 16;   // width of the tag fields on the channels

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // priority class codes
  localparam logic [CLASS_BITS-1:0] CLASS_HI  = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_MID = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_LO  = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_BAD = 2'd3;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

endpackage

// ===== hdl/tcspq_if.sv =====
// Valid/ready channel interfaces for the queue's request and result words.
interface tcspq_in_if import tcspq_pkg::*; (input logic clk);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [CLASS_BITS-1:0] priority_class;
  logic [TAG_W-1:0]      item_tag;

  modport source (output valid, action, priority_class, item_tag, input ready);
  modport sink   (input valid, action, priority_class, item_tag, output ready);
endinterface

interface tcspq_out_if import tcspq_pkg::*; (input logic clk);
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [TAG_W-1:0]      served_tag;
  logic [CLASS_BITS-1:0] served_class;

  modport source (output valid, status, served_tag, served_class, input ready);
  modport sink   (input valid, status, served_tag, served_class, output ready);
endinterface

// ===== hdl/tcspq_mem.sv =====
// Tag store: simple dual-port RAM, one write and one registered read per cycle.
module tcspq_mem #(
  parameter int ENTRIES   = 48,
  parameter int DATA_BITS = 16,
  parameter int ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem_r [ENTRIES];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/three_class_strict_priority_queue_unit.sv =====
// Three-class strict priority queue: top level with ring pointers and result stage.
//
// Usage notes:
// - in_ch carries request words: action (enqueue / dequeue), priority_class and
//   item_tag. A word is taken when in_ch.valid and in_ch.ready are both high.
// - out_ch returns exactly one status word per request, in request order.
// - Enqueue, all-empty and dropped requests: result is registered at the accept
//   edge, shows on out_ch the next cycle; one such word per cycle if out_ch is ready.
// - Served dequeue: the tag comes from the registered-read tag RAM, so the
//   result passes the pending stage and then the result register, and in_ch.ready
//   is low while the read is pending; no new word is taken until it completes.
// - Class 0 is always drained first; within a class, order is FIFO.
// - Each class owns a ring of DEPTH entries in one shared RAM of 3*DEPTH words.
//   Enqueue into a full ring returns status full; class 3 returns invalid.
// - Reset (rst_n low, synchronous) clears head, tail, fill, pend and out valid;
//   the RAM is not cleared and no sweep is run, so the block takes words right away.
// - When out_ch stalls, the result register holds its word and in_ch.ready
//   drops until the word is taken; nothing is lost or repeated.
module three_class_strict_priority_queue_unit import tcspq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tcspq_in_if.sink    in_ch,
  tcspq_out_if.source out_ch
);

  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int ENTRIES    = NUM_CLASSES * DEPTH;
  localparam int ADDR_BITS  = $clog2(ENTRIES);
  // only the low tag bits are kept; the channel is TAG_W wide
  localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  // per-class ring state
  logic [PTR_BITS-1:0] head_r [NUM_CLASSES];
  logic [PTR_BITS-1:0] tail_r [NUM_CLASSES];
  logic [CNT_BITS-1:0] fill_r [NUM_CLASSES];
  logic [PTR_BITS-1:0] head_nxt [NUM_CLASSES];
  logic [PTR_BITS-1:0] tail_nxt [NUM_CLASSES];
  logic [CNT_BITS-1:0] fill_nxt [NUM_CLASSES];

  // pending read stage (served dequeue waiting for RAM data)
  logic                  pend_valid_r;
  logic [CLASS_BITS-1:0] pend_class_r;

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [TAG_W-1:0]      out_tag_r;
  logic [CLASS_BITS-1:0] out_class_r;

  logic                   out_free;
  logic                   accept;
  logic                   is_enq;
  logic [NUM_CLASSES-1:0] nonempty;
  logic [NUM_CLASSES-1:0] full;
  logic [NUM_CLASSES-1:0] sel;
  logic [NUM_CLASSES-1:0] enq_hit;
  logic [NUM_CLASSES-1:0] deq_hit;
  logic                   cls_full;
  logic [CLASS_BITS-1:0]  sel_class;
  logic                   deq_served;
  status_t                imm_status;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [STORE_BITS-1:0]  rd_data;

  // Stall on a pending RAM read or a result word nobody has taken.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !pend_valid_r && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_enq      = (in_ch.action == ACT_ENQ);

  // Strict priority: lowest class number with a tag wins.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (fill_r[c] != '0);
      full[c]     = (fill_r[c] == CNT_BITS'(DEPTH));
    end
    sel[0] = nonempty[0];
    sel[1] = nonempty[1] && !nonempty[0];
    sel[2] = nonempty[2] && !nonempty[1] && !nonempty[0];
  end

  always_comb begin
    cls_full  = 1'b0;
    sel_class = CLASS_HI;
    wr_addr   = '0;
    rd_addr   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      enq_hit[c] = accept && is_enq && (in_ch.priority_class == CLASS_BITS'(c)) && !full[c];
      deq_hit[c] = accept && !is_enq && sel[c];
      if (in_ch.priority_class == CLASS_BITS'(c)) begin
        cls_full = full[c];
        wr_addr  = ADDR_BITS'(c * DEPTH) + ADDR_BITS'(tail_r[c]);
      end
      if (sel[c]) begin
        sel_class = CLASS_BITS'(c);
        rd_addr   = ADDR_BITS'(c * DEPTH) + ADDR_BITS'(head_r[c]);
      end
    end
  end

  assign wr_en      = |enq_hit;
  assign deq_served = |deq_hit;

  // Ring pointer and fill count updates (wrap at DEPTH-1).
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      fill_nxt[c] = fill_r[c];
      if (enq_hit[c]) begin
        tail_nxt[c] = (tail_r[c] == PTR_BITS'(DEPTH - 1)) ? '0 : tail_r[c] + 1'b1;
        fill_nxt[c] = fill_r[c] + 1'b1;
      end
      if (deq_hit[c]) begin
        head_nxt[c] = (head_r[c] == PTR_BITS'(DEPTH - 1)) ? '0 : head_r[c] + 1'b1;
        fill_nxt[c] = fill_r[c] - 1'b1;
      end
    end
  end

  // Status for words that finish without a RAM read.
  always_comb begin
    if (is_enq) begin
      if (in_ch.priority_class == CLASS_BAD) begin
        imm_status = ST_INVALID;
      end else if (cls_full) begin
        imm_status = ST_FULL;
      end else begin
        imm_status = ST_ENQUEUED;
      end
    end else begin
      imm_status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        fill_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c] <= head_nxt[c];
        tail_r[c] <= tail_nxt[c];
        fill_r[c] <= fill_nxt[c];
      end
    end
  end

  // Pending stage and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pend_valid_r && out_free) begin
        pend_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else if (accept && deq_served) begin
        pend_valid_r <= 1'b1;
        out_valid_r  <= 1'b0;
      end else if (accept) begin
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && deq_served) begin
      pend_class_r <= sel_class;
    end
    if (pend_valid_r && out_free) begin
      out_status_r <= ST_SERVED;
      out_tag_r    <= TAG_W'(rd_data);
      out_class_r  <= pend_class_r;
    end else if (accept && !deq_served) begin
      out_status_r <= imm_status;
      out_tag_r    <= '0;
      out_class_r  <= CLASS_HI;
    end
  end

  tcspq_mem #(
    .ENTRIES   (ENTRIES),
    .DATA_BITS (STORE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.item_tag[STORE_BITS-1:0]),
    .rd_en   (deq_served),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.served_tag   = out_tag_r;
  assign out_ch.served_class = out_class_r;

  // ---- assertions ----
  generate
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_fill_chk
      a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_r[g] <= CNT_BITS'(DEPTH))
        else $error("fill count above ring depth");
    end
  endgenerate

  a_deq_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_enq && (nonempty != '0)) |=> pend_valid_r)
    else $error("served dequeue did not start a RAM read");

  a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !accept)
    else $error("word taken while a RAM read is pending");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_SERVED) |->
      (out_tag_r == '0 && out_class_r == CLASS_HI))
    else $error("unserved result carries a tag or class");

  a_pend_class: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_class_r != CLASS_BAD))
    else $error("pending read from a nonexistent class");

endmodule
